>>> rtl/bounded_fifo_with_stats_unit_defines.svh
// Assertion macros shared by the bounded FIFO RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef BOUNDED_FIFO_WITH_STATS_UNIT_DEFINES_SVH
`define BOUNDED_FIFO_WITH_STATS_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// expression must hold at every clock edge outside reset
`define BFS_ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// when ante holds, cons must hold in the next cycle
`define BFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define BFS_ASSERT_HOLDS(lbl, clk, rst_n, expr, msg)
`define BFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/bfs_pkg.sv
// Shared types and constants for the bounded FIFO with statistics.
// No dependencies.
package bfs_pkg;

    localparam int WORD_W           = 32;
    localparam int OCC_W            = 5;
    localparam int LIMIT_W          = 5;
    localparam int OUT_CNT_W        = 32;
    localparam int DEPTH_DEF        = 16;
    localparam int COUNTER_BITS_DEF = 32;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // register index taken from paddr[2]
    localparam logic CFG_IDX_LIMIT = 1'b0;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef struct packed {
        logic status;   // 1: full on push or empty on pop
        logic pop_ok;   // read data holds the popped word
    } t_step_info;

endpackage

>>> rtl/bfs_slot_ram.sv
// Slot storage for the FIFO ring: one write port, one registered read port.
// Depends on bfs_pkg for the word width.
module bfs_slot_ram #(
    parameter int DEPTH = bfs_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [bfs_pkg::WORD_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [bfs_pkg::WORD_W-1:0] o_rd_data
);
    import bfs_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/bfs_ctrl.sv
// Ring pointers, fill level, statistics counters and result register.
// Depends on bfs_pkg and bounded_fifo_with_stats_unit_defines.svh.
`include "bounded_fifo_with_stats_unit_defines.svh"

module bfs_ctrl #(
    parameter int DEPTH        = bfs_pkg::DEPTH_DEF,
    parameter int COUNTER_BITS = bfs_pkg::COUNTER_BITS_DEF,
    parameter int AW           = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bfs_pkg::LIMIT_W-1:0]   i_limit,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bfs_pkg::t_step_info           o_info,
    output logic [bfs_pkg::OCC_W-1:0]     o_occupancy,
    output logic [bfs_pkg::OUT_CNT_W-1:0] o_push_tries,
    output logic [bfs_pkg::OUT_CNT_W-1:0] o_pop_tries,
    output logic [bfs_pkg::OUT_CNT_W-1:0] o_pushes_done,
    output logic [bfs_pkg::OUT_CNT_W-1:0] o_pops_done,
    output logic                          o_wr_en,
    output logic [AW-1:0]                 o_wr_addr,
    output logic                          o_rd_en,
    output logic [AW-1:0]                 o_rd_addr
);
    import bfs_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
    localparam logic [AW-1:0]    LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_C   = CMP_W'(DEPTH);

    logic [AW-1:0]           r_head, n_head;
    logic [AW-1:0]           r_tail, n_tail;
    logic [FILL_W-1:0]       r_fill, n_fill;
    logic [COUNTER_BITS-1:0] r_push_try, n_push_try;
    logic [COUNTER_BITS-1:0] r_pop_try, n_pop_try;
    logic [COUNTER_BITS-1:0] r_push_ok, n_push_ok;
    logic [COUNTER_BITS-1:0] r_pop_ok, n_pop_ok;
    logic                    r_out_valid, n_out_valid;
    t_step_info              r_info, n_info;

    logic             accept;
    logic             is_pop;
    logic             full;
    logic             empty;
    logic             push_ok;
    logic             pop_ok;
    logic [CMP_W-1:0] limit_c;
    logic [CMP_W-1:0] eff_limit;

    logic [FILL_W+OCC_W-1:0]           fill_ext;
    logic [COUNTER_BITS+OUT_CNT_W-1:0] push_try_ext;
    logic [COUNTER_BITS+OUT_CNT_W-1:0] pop_try_ext;
    logic [COUNTER_BITS+OUT_CNT_W-1:0] push_ok_ext;
    logic [COUNTER_BITS+OUT_CNT_W-1:0] pop_ok_ext;

    // a new word may enter whenever the result register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_pop     = (t_op'(i_op) == OP_POP);

    // limit above the ring depth acts as the depth
    assign limit_c   = CMP_W'(i_limit);
    assign eff_limit = (limit_c > DEPTH_C) ? DEPTH_C : limit_c;
    assign full      = CMP_W'(r_fill) >= eff_limit;
    assign empty     = (r_fill == '0);
    assign push_ok   = accept && !is_pop && !full;
    assign pop_ok    = accept && is_pop && !empty;

    assign o_wr_en   = push_ok;
    assign o_wr_addr = r_tail;
    assign o_rd_en   = pop_ok;
    assign o_rd_addr = r_head;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_push_try  = r_push_try;
        n_pop_try   = r_pop_try;
        n_push_ok   = r_push_ok;
        n_pop_ok    = r_pop_ok;
        n_info      = r_info;
        n_out_valid = r_out_valid && !i_out_ready;
        if (accept) begin
            n_out_valid   = 1'b1;
            n_info.status = is_pop ? empty : full;
            n_info.pop_ok = pop_ok;
            if (is_pop) begin
                n_pop_try = r_pop_try + 1'b1;
            end else begin
                n_push_try = r_push_try + 1'b1;
            end
        end
        if (push_ok) begin
            n_tail    = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
            n_fill    = r_fill + 1'b1;
            n_push_ok = r_push_ok + 1'b1;
        end
        if (pop_ok) begin
            n_head   = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
            n_fill   = r_fill - 1'b1;
            n_pop_ok = r_pop_ok + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_push_try  <= '0;
            r_pop_try   <= '0;
            r_push_ok   <= '0;
            r_pop_ok    <= '0;
            r_out_valid <= 1'b0;
            r_info      <= '0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_push_try  <= n_push_try;
            r_pop_try   <= n_pop_try;
            r_push_ok   <= n_push_ok;
            r_pop_ok    <= n_pop_ok;
            r_out_valid <= n_out_valid;
            r_info      <= n_info;
        end
    end

    // state only moves on accept, which needs the result register free or draining,
    // so the live counters and fill are the reported values
    assign fill_ext     = {{OCC_W{1'b0}}, r_fill};
    assign push_try_ext = {{OUT_CNT_W{1'b0}}, r_push_try};
    assign pop_try_ext  = {{OUT_CNT_W{1'b0}}, r_pop_try};
    assign push_ok_ext  = {{OUT_CNT_W{1'b0}}, r_push_ok};
    assign pop_ok_ext   = {{OUT_CNT_W{1'b0}}, r_pop_ok};

    assign o_out_valid   = r_out_valid;
    assign o_info        = r_info;
    assign o_occupancy   = fill_ext[OCC_W-1:0];
    assign o_push_tries  = push_try_ext[OUT_CNT_W-1:0];
    assign o_pop_tries   = pop_try_ext[OUT_CNT_W-1:0];
    assign o_pushes_done = push_ok_ext[OUT_CNT_W-1:0];
    assign o_pops_done   = pop_ok_ext[OUT_CNT_W-1:0];

    `BFS_ASSERT_HOLDS(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(DEPTH), "fill above depth")
    `BFS_ASSERT_HOLDS(a_empty_ptrs, i_clk, i_rst_n, (r_fill != '0) || (r_head == r_tail), "empty ring with pointers apart")
    `BFS_ASSERT_NEXT(a_push_fill, i_clk, i_rst_n, push_ok, r_fill == $past(r_fill) + 1'b1, "push did not raise fill")
    `BFS_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, pop_ok, r_pop_ok == $past(r_pop_ok) + 1'b1, "pop did not bump count")
    `BFS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_out_valid && !i_out_ready, $stable(r_fill) && $stable(r_push_try) && $stable(r_pop_try), "state moved under stall")

endmodule

>>> rtl/bounded_fifo_with_stats_unit.sv
// Top level of the bounded FIFO with statistics: APB limit register,
// controller and slot RAM. Depends on bfs_pkg, bfs_ctrl and bfs_slot_ram.
//
//   channel  | handshake                     | fields
//   ---------+-------------------------------+----------------------------------
//   input    | i_in_valid / o_in_ready       | i_op, i_value
//   result   | o_out_valid / i_out_ready     | o_status, o_popped, o_occupancy,
//            |                               | o_push_tries, o_pop_tries,
//            |                               | o_pushes_done, o_pops_done
//   config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One word per cycle sustained while results are taken; the result shows in the
// cycle after accept, as the slot RAM's registered read port needs on a pop.
// A stalled result holds o_in_ready low until it is taken.
// Reset is synchronous: pointers, fill and counters clear, limit returns to 16.
// Slot contents are not cleared; only written slots are ever read.
module bounded_fifo_with_stats_unit #(
    parameter int DEPTH        = bfs_pkg::DEPTH_DEF,
    parameter int COUNTER_BITS = bfs_pkg::COUNTER_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bfs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bfs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bfs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_op,
    input  logic signed [bfs_pkg::WORD_W-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_status,
    output logic signed [bfs_pkg::WORD_W-1:0] o_popped,
    output logic [bfs_pkg::OCC_W-1:0]        o_occupancy,
    output logic [bfs_pkg::OUT_CNT_W-1:0]    o_push_tries,
    output logic [bfs_pkg::OUT_CNT_W-1:0]    o_pop_tries,
    output logic [bfs_pkg::OUT_CNT_W-1:0]    o_pushes_done,
    output logic [bfs_pkg::OUT_CNT_W-1:0]    o_pops_done
);
    import bfs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [LIMIT_W-1:0] r_limit;
    logic               cfg_wr;
    logic               sel_limit;

    t_step_info         info;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [WORD_W-1:0]  rd_data;

    // register index is the word address; byte offset bits are ignored
    assign pready    = 1'b1;
    assign sel_limit = (paddr[2] == CFG_IDX_LIMIT);
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign prdata    = sel_limit ? {{(APB_DATA_W - LIMIT_W){1'b0}}, r_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (cfg_wr && sel_limit) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    bfs_ctrl #(
        .DEPTH        (DEPTH),
        .COUNTER_BITS (COUNTER_BITS),
        .AW           (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_limit       (r_limit),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_info        (info),
        .o_occupancy   (o_occupancy),
        .o_push_tries  (o_push_tries),
        .o_pop_tries   (o_pop_tries),
        .o_pushes_done (o_pushes_done),
        .o_pops_done   (o_pops_done),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr)
    );

    bfs_slot_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (WORD_W'(i_value)),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // popped word is zero on pushes and on a failed pop
    assign o_status = info.status;
    assign o_popped = info.pop_ok ? signed'(rd_data) : '0;

endmodule
